// ===== rtl/core/moavg_pkg.sv =====
// shared types and constants of the multichannel oversample averager
package moavg_pkg;

    // default sizing of the sample store
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int MAX_SAMPLES_DEF  = 16;
    localparam int SAMPLE_BITS_DEF  = 16;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT  = 1'd1;

    // function codes
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // input word
    typedef struct packed {
        logic        func;
        logic [15:0] sample;
        logic [3:0]  index;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [15:0] average;
        logic        bad_index;
    } out_word_t;

endpackage

// ===== rtl/core/multichannel_oversample_averager_unit.sv =====
// multichannel oversample averager: sample ring store and per-rank mean
//
// Input words on s_*: func 0 stores a conversion sample at the ring write
// position and yields no result word; func 1 asks for the mean of one
// rank and yields one result word on m_* (average, bad_index).
// channel_count (index 0) and sample_count (index 1) are written on the
// cfg_* port; the user must write them only while the block is idle, as
// the block itself does not enforce it; they take effect once registered.
// A query walks the rank's samples through one shared adder, one memory
// read per cycle, then runs a restoring divide on the same adder, one
// quotient bit per cycle. A bad rank index skips both and goes straight
// to the result. s_ready is low for the whole query and returns with the
// result, so no new word is taken before the last query is through.
// After reset the store is cleared to zero, one entry per cycle over all
// MAX_CHANNELS * MAX_SAMPLES entries, with s_ready low; configuration
// writes are taken during that pass.
// The result sits in an output register: a stalled receiver does not
// block stores, and only holds back the end of the next query.
module multichannel_oversample_averager_unit #(
    parameter int MAX_CHANNELS = moavg_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_SAMPLES  = moavg_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS  = moavg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_we,
    input  logic [moavg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [moavg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  moavg_pkg::in_word_t                  s_data,
    // result words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output moavg_pkg::out_word_t                 m_data
);

    localparam int STORE_DEPTH = MAX_CHANNELS * MAX_SAMPLES;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LEN_W       = ADDR_W + 1;
    localparam int CW          = moavg_pkg::CFG_DATA_W;
    localparam int NS_W        = CW;
    localparam int REM_W       = NS_W + 1;
    localparam int SUM_W       = SAMPLE_BITS + NS_W;
    localparam int ALU_W       = SUM_W + 1;
    localparam int CNT_W       = $clog2(SUM_W);

    localparam logic [CW-1:0] CH_CAP = CW'(MAX_CHANNELS);
    localparam logic [CW-1:0] NS_CAP = (MAX_SAMPLES > 31) ? 5'd31 : CW'(MAX_SAMPLES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

    // sequencer states
    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic [CW-1:0]              ch_cfg_reg, ns_cfg_reg;
    logic [ADDR_W-1:0]          wpos_reg, wpos_next;
    logic [ADDR_W-1:0]          clr_reg, clr_next;
    logic [ADDR_W-1:0]          addr_reg, addr_next;
    logic [NS_W-1:0]            left_reg, left_next;
    logic                       pend_reg, pend_next;
    logic [SUM_W-1:0]           acc_reg, acc_next;
    logic [NS_W-1:0]            rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       bad_reg, bad_next;
    logic                       m_valid_reg, m_valid_next;
    moavg_pkg::out_word_t       m_data_reg, m_data_next;

    logic [SAMPLE_BITS-1:0]     store_mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0]     mem_q_reg;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [SAMPLE_BITS-1:0]     mem_wdata;
    logic                       mem_re;

    logic [CW-1:0]              ch_used, ch_ring, ns_used;
    logic [LEN_W-1:0]           ring_len, pos_w, pos_inc;
    logic                       s_fire;
    logic [REM_W-1:0]           shifted;
    logic [ALU_W-1:0]           alu_a, alu_b, alu_res;
    logic                       div_lt;

    // effective configuration
    always_comb begin
        ch_used = (ch_cfg_reg > CH_CAP) ? CH_CAP : ch_cfg_reg;
        ch_ring = (ch_used == '0) ? CW'(1) : ch_used;
        if (ns_cfg_reg == '0) begin
            ns_used = CW'(1);
        end else begin
            ns_used = (ns_cfg_reg > NS_CAP) ? NS_CAP : ns_cfg_reg;
        end
        ring_len = LEN_W'(ch_ring) * LEN_W'(ns_used);
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_cfg_reg <= CW'(1);
            ns_cfg_reg <= CW'(1);
        end else if (cfg_we) begin
            if (cfg_index == moavg_pkg::REG_CHANNEL_COUNT) begin
                ch_cfg_reg <= cfg_wdata;
            end else if (cfg_index == moavg_pkg::REG_SAMPLE_COUNT) begin
                ns_cfg_reg <= cfg_wdata;
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // ring write position for a store word
    always_comb begin
        pos_w   = ({1'b0, wpos_reg} < ring_len) ? {1'b0, wpos_reg} : '0;
        pos_inc = pos_w + LEN_W'(1);
        if (pos_inc >= ring_len) begin
            pos_inc = '0;
        end
    end

    // shared adder: accumulate in the sum phase, trial subtract in the divide
    always_comb begin
        shifted = {rem_reg, acc_reg[SUM_W-1]};
        if (state_reg == ST_DIV) begin
            alu_a = ALU_W'(shifted);
            alu_b = -ALU_W'(ns_used);
        end else begin
            alu_a = ALU_W'(acc_reg);
            alu_b = ALU_W'(mem_q_reg);
        end
        alu_res = alu_a + alu_b;
        div_lt  = alu_res[ALU_W-1];
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        wpos_next    = wpos_reg;
        clr_next     = clr_reg;
        addr_next    = addr_reg;
        left_next    = left_reg;
        pend_next    = 1'b0;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = clr_reg;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        case (state_reg)
            ST_CLR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.func == moavg_pkg::FUNC_STORE) begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_w[ADDR_W-1:0];
                        mem_wdata = SAMPLE_BITS'(s_data.sample);
                        wpos_next = pos_inc[ADDR_W-1:0];
                    end else if (CW'(s_data.index) >= ch_used) begin
                        bad_next   = 1'b1;
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        bad_next   = 1'b0;
                        acc_next   = '0;
                        addr_next  = ADDR_W'(s_data.index);
                        left_next  = ns_used;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                // one read issued per cycle, its data added in the next cycle
                if (left_reg != '0) begin
                    mem_re    = 1'b1;
                    addr_next = addr_reg + ADDR_W'(ch_used);
                    left_next = left_reg - NS_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    acc_next = alu_res[SUM_W-1:0];
                end
                if (left_reg == '0 && !pend_reg) begin
                    rem_next   = '0;
                    cnt_next   = CNT_W'(SUM_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // restoring divide, one quotient bit per cycle
                rem_next = div_lt ? shifted[NS_W-1:0] : alu_res[NS_W-1:0];
                acc_next = {acc_reg[SUM_W-2:0], !div_lt};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.average   = bad_reg ? 16'd0 : 16'(acc_reg);
                    m_data_next.bad_index = bad_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            wpos_reg    <= '0;
            clr_reg     <= '0;
            left_reg    <= '0;
            pend_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wpos_reg    <= wpos_next;
            clr_reg     <= clr_next;
            left_reg    <= left_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        bad_reg    <= bad_next;
        m_data_reg <= m_data_next;
    end

    // sample store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= store_mem[addr_reg];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a bad rank index always reports a zero average
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_index |-> m_data.average == 16'd0)
        else $error("bad index result with nonzero average");

    // no input word is taken while a query or the clearing pass runs
    a_busy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR || state_reg == ST_SUM || state_reg == ST_DIV)
        |-> !s_ready)
        else $error("input accepted while busy");

    // a pending read only follows a cycle that issued it in the sum phase
    a_pend_src: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $past(state_reg == ST_SUM) && state_reg == ST_SUM)
        else $error("read data pending outside the sum phase");

    // a new result word never overwrites one the receiver has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready && state_reg == ST_DONE |=> state_reg == ST_DONE)
        else $error("result word overwritten");

endmodule
